/* rtl/sss_pkg.sv */
// Shared types, command codes and segment font for the seven-segment scan driver.
// Used by every module of the block; depends on nothing.
`default_nettype none
package sss_pkg;

  localparam int unsigned DIGIT_COUNT = 3;
  localparam int unsigned SEG_W       = 8;

  localparam logic [2:0] KIND_NUMBER   = 3'd0;
  localparam logic [2:0] KIND_DASHES   = 3'd1;
  localparam logic [2:0] KIND_RAW      = 3'd2;
  localparam logic [2:0] KIND_UNITS_DP = 3'd3;
  localparam logic [2:0] KIND_ALL_DP   = 3'd4;
  localparam logic [2:0] KIND_TICK     = 3'd5;

  localparam logic [SEG_W-1:0] SEG_DP = 8'h10;
  localparam logic [SEG_W-1:0] SEG_G  = 8'h40;

  localparam logic [9:0] NUMBER_MAX  = 10'd999;
  localparam logic [9:0] BLANK_BELOW = 10'd100;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [15:0] number_value;
    logic [7:0]        left_mask;
    logic [7:0]        middle_mask;
    logic [7:0]        right_mask;
    logic              point_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] segment_drive;
    logic [2:0] digit_enable;
    logic [1:0] scanned_digit;
  } out_item_t;

  typedef struct packed {
    logic [SEG_W-1:0] left_seg;
    logic [SEG_W-1:0] middle_seg;
    logic [SEG_W-1:0] right_seg;
  } glyph_set_t;

  function automatic logic [SEG_W-1:0] glyph(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 8'hAF;
      4'd1:    seg = 8'hA0;
      4'd2:    seg = 8'hC7;
      4'd3:    seg = 8'hE5;
      4'd4:    seg = 8'hE8;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h6F;
      4'd7:    seg = 8'hA1;
      4'd8:    seg = 8'hEF;
      4'd9:    seg = 8'hED;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

/* rtl/seven_segment_scan_driver.sv */
// Three-digit seven-segment scan driver with an input register and a result register.
// A tick goes via the input and result registers; one item per cycle unless stalled.
// Commands update the digit masks in the cycle after acceptance and produce no result.
// The result register parts the two sides, so a waiting result blocks only ticks.
// Synchronous active-low reset blanks all digits and sets the scan to the left digit.
// Depends on sss_pkg and sss_number_encode.
`default_nettype none
module seven_segment_scan_driver (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sss_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sss_pkg::out_item_t      out_item
);
  import sss_pkg::*;

  in_item_t         item_r;
  logic             item_valid_r;
  logic [SEG_W-1:0] digit_r   [DIGIT_COUNT];
  logic [SEG_W-1:0] digit_nxt [DIGIT_COUNT];
  logic [1:0]       scan_r;
  logic [1:0]       scan_nxt;
  logic [1:0]       pos;
  logic             out_valid_r;
  out_item_t        out_r;
  out_item_t        out_nxt;
  glyph_set_t       glyphs;
  logic             is_tick;
  logic             advance;

  sss_number_encode u_encode (
    .number_value (item_r.number_value),
    .glyphs       (glyphs)
  );

  assign is_tick  = (item_r.kind == KIND_TICK);
  assign advance  = item_valid_r && (!is_tick || !out_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;
  assign pos      = (scan_r < 2'(DIGIT_COUNT)) ? scan_r : 2'd0;

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      digit_nxt[i] = digit_r[i];
    end
    case (item_r.kind)
      KIND_NUMBER: begin
        digit_nxt[0] = glyphs.left_seg;
        digit_nxt[1] = glyphs.middle_seg;
        digit_nxt[2] = glyphs.right_seg | (digit_r[2] & SEG_DP);
      end
      KIND_DASHES: begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          digit_nxt[i] = SEG_G;
        end
      end
      KIND_RAW: begin
        digit_nxt[0] = item_r.left_mask;
        digit_nxt[1] = item_r.middle_mask;
        digit_nxt[2] = item_r.right_mask;
      end
      KIND_UNITS_DP: begin
        digit_nxt[2] = item_r.point_on ? (digit_r[2] | SEG_DP) : (digit_r[2] & ~SEG_DP);
      end
      KIND_ALL_DP: begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          digit_nxt[i] = item_r.point_on ? (digit_r[i] | SEG_DP) : (digit_r[i] & ~SEG_DP);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_nxt.segment_drive = ~digit_r[pos];
    out_nxt.digit_enable  = (digit_r[pos] != '0) ? (3'b001 << pos) : 3'b000;
    out_nxt.scanned_digit = pos;
    scan_nxt              = (pos == 2'(DIGIT_COUNT - 1)) ? 2'd0 : pos + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      scan_r       <= '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_r[i] <= '0;
      end
    end else begin
      if (!item_valid_r || advance) begin
        item_valid_r <= in_valid;
      end
      if (advance) begin
        if (is_tick) begin
          out_valid_r <= 1'b1;
          scan_r      <= scan_nxt;
        end else begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
          end
          for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_r[i] <= digit_nxt[i];
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!item_valid_r || advance) begin
      item_r <= in_item;
    end
    if (advance && is_tick) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

/* rtl/sss_number_encode.sv */
// Clamps a signed number to 0..999 and converts it to three segment glyphs, the left one blank below 100.
// Depends on sss_pkg for the font, the clamp limit and the blanking threshold.
`default_nettype none
module sss_number_encode (
  input  wire logic signed [15:0] number_value,
  output sss_pkg::glyph_set_t     glyphs
);
  import sss_pkg::*;

  logic [9:0]  num;
  logic [15:0] hund_prod;
  logic [3:0]  hund;
  logic [9:0]  rem_full;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  unit_full;
  logic [3:0]  units;

  always_comb begin
    if (number_value[15]) begin
      num = '0;
    end else if (number_value > 16'sd999) begin
      num = NUMBER_MAX;
    end else begin
      num = number_value[9:0];
    end
  end

  // Division by constants as reciprocal multiplies, exact over 0..999 and 0..99.
  assign hund_prod = 16'(num) * 16'd41;
  assign hund      = hund_prod[15:12];
  assign rem_full  = num - 10'(hund) * 10'd100;
  assign rem       = rem_full[6:0];
  assign tens_prod = 15'(rem) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = 7'(tens) * 7'd10;
  assign unit_full = rem - tens_x10;
  assign units     = unit_full[3:0];

  assign glyphs.left_seg   = (num < BLANK_BELOW) ? '0 : glyph(hund);
  assign glyphs.middle_seg = glyph(tens);
  assign glyphs.right_seg  = glyph(units);

endmodule
`default_nettype wire

/* rtl/sss_checker.sv */
// Port-level checks for the seven-segment scan driver, bound to its top level.
// Depends on sss_pkg for the item types.
`default_nettype none
module sss_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire sss_pkg::out_item_t out_item
);
  import sss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("Result item changed while stalled.");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.scanned_digit != 2'd3)
    else $error("Scanned digit index out of range.");

  a_enable_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.digit_enable == 3'b000 ||
      (out_item.scanned_digit == 2'd0 && out_item.digit_enable == 3'b001) ||
      (out_item.scanned_digit == 2'd1 && out_item.digit_enable == 3'b010) ||
      (out_item.scanned_digit == 2'd2 && out_item.digit_enable == 3'b100))
    else $error("Digit enable does not match the scanned digit.");

  a_blank_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.digit_enable == 3'b000) == (out_item.segment_drive == 8'hFF))
    else $error("Enable given to a blank digit or withheld from a lit one.");

endmodule

bind seven_segment_scan_driver sss_checker u_sss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
